// ===== design/fpalu_pkg.sv =====
// Package for the fixed-point ALU: widths, operation and status codes,
// the classified request type and the saturation helper.
// No dependencies.
package fpalu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int DIV_W     = DATA_W + FRAC_BITS;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int LAST      = DIV_W + 1;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_COMPARE  = 4'd4;
  localparam logic [3:0] OP_MIN      = 4'd5;
  localparam logic [3:0] OP_MAX      = 4'd6;
  localparam logic [3:0] OP_INC      = 4'd7;
  localparam logic [3:0] OP_DEC      = 4'd8;
  localparam logic [3:0] OP_TO_INT   = 4'd9;
  localparam logic [3:0] OP_FROM_INT = 4'd10;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] UNIT_SIMPLE = 2'd0;
  localparam logic [1:0] UNIT_MUL    = 2'd1;
  localparam logic [1:0] UNIT_DIV    = 2'd2;

  localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] MAG_POS = PROD_W'(MAX_VAL);
  localparam logic [PROD_W-1:0] MAG_NEG = PROD_W'(MIN_VAL);
  localparam logic [PROD_W-1:0] MUL_HALF = (PROD_W'(1) << FRAC_BITS) >> 1;

  typedef struct packed {
    logic [1:0]        unit;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] res;
    logic [1:0]        status;
    logic              less;
    logic              equal;
    logic              greater;
  } uop_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [1:0]        status;
  } sat_t;

  // Applies a sign to a magnitude and clamps to the signed 32-bit range.
  function automatic sat_t sat_mag(input logic [PROD_W-1:0] mag, input logic neg);
    sat_t s;
    s.status = ST_OK;
    if (neg) begin
      if (mag > MAG_NEG) begin
        s.value  = MIN_VAL;
        s.status = ST_OVERFLOW;
      end else begin
        s.value = ~mag[DATA_W-1:0] + DATA_W'(1);
      end
    end else begin
      if (mag > MAG_POS) begin
        s.value  = MAX_VAL;
        s.status = ST_OVERFLOW;
      end else begin
        s.value = mag[DATA_W-1:0];
      end
    end
    return s;
  endfunction

endpackage

// ===== design/fpalu_if.sv =====
// Request and response channel interfaces of the fixed-point ALU.
// Depends on fpalu_pkg.
interface fpalu_req_if import fpalu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [3:0]        req_type;
  logic [DATA_W-1:0] operand_a;
  logic [DATA_W-1:0] operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fpalu_rsp_if import fpalu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_value;
  logic              a_less;
  logic              a_equal;
  logic              a_greater;
  logic [1:0]        status_code;
  modport source (output valid, result_value, a_less, a_equal, a_greater, status_code,
                  input ready);
  modport sink (input valid, result_value, a_less, a_equal, a_greater, status_code,
                output ready);
endinterface

// ===== design/fpalu_front.sv =====
// Front end: accepts requests, computes flags and the simple operations,
// and tags multiply and divide for the back end. Depends on fpalu_pkg.
module fpalu_front import fpalu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fpalu_req_if.sink  req,
  output logic       push_valid,
  input  logic       push_ready,
  output uop_t       push_uop
);

  logic                     valid;
  uop_t                     uop;
  uop_t                     uop_next;
  logic signed [DATA_W:0]   ax;
  logic signed [DATA_W:0]   yx;
  logic signed [DATA_W:0]   arith;
  logic signed [PROD_W-1:0] shifted;
  logic signed [DATA_W-1:0] sa;
  logic signed [DATA_W-1:0] sb;
  logic [DATA_W:0]          fi_top;

  assign req.ready  = !valid || push_ready;
  assign push_valid = valid;
  assign push_uop   = uop;

  always_comb begin
    sa = req.operand_a;
    sb = req.operand_b;
    ax = {sa[DATA_W-1], sa};
    yx = (req.req_type == OP_INC || req.req_type == OP_DEC) ? (DATA_W+1)'(1)
                                                            : {sb[DATA_W-1], sb};
    arith   = (req.req_type == OP_SUB || req.req_type == OP_DEC) ? ax - yx : ax + yx;
    shifted = PROD_W'(sa) <<< FRAC_BITS;
    fi_top  = shifted[PROD_W-1:DATA_W-1];

    uop_next.unit    = UNIT_SIMPLE;
    uop_next.a       = req.operand_a;
    uop_next.b       = req.operand_b;
    uop_next.res     = '0;
    uop_next.status  = ST_OK;
    uop_next.less    = sa < sb;
    uop_next.equal   = sa == sb;
    uop_next.greater = sa > sb;

    unique case (req.req_type)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (arith[DATA_W] != arith[DATA_W-1]) begin
          uop_next.res    = arith[DATA_W] ? MIN_VAL : MAX_VAL;
          uop_next.status = ST_OVERFLOW;
        end else begin
          uop_next.res = arith[DATA_W-1:0];
        end
      end
      OP_MUL: uop_next.unit = UNIT_MUL;
      OP_DIV: begin
        if (sb == '0) begin
          uop_next.status = ST_DIV_ZERO;
        end else begin
          uop_next.unit = UNIT_DIV;
        end
      end
      OP_MIN: uop_next.res = (sa < sb) ? req.operand_a : req.operand_b;
      OP_MAX: uop_next.res = (sa > sb) ? req.operand_a : req.operand_b;
      OP_TO_INT: uop_next.res = DATA_W'(sa >>> FRAC_BITS);
      OP_FROM_INT: begin
        if (fi_top != '0 && fi_top != '1) begin
          uop_next.res    = sa[DATA_W-1] ? MIN_VAL : MAX_VAL;
          uop_next.status = ST_OVERFLOW;
        end else begin
          uop_next.res = shifted[DATA_W-1:0];
        end
      end
      default: uop_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      uop <= uop_next;
    end
  end

endmodule

// ===== design/fpalu_queue.sv =====
// Two-entry queue of classified requests between the front and back ends.
// Depends on fpalu_pkg.
module fpalu_queue import fpalu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  uop_t push_uop,
  output logic pop_valid,
  input  logic pop_ready,
  output uop_t pop_uop
);

  uop_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_uop    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_uop;
    end
  end

endmodule

// ===== design/fpalu_back.sv =====
// Back end: multiplier stage, one restoring-division stage per quotient bit,
// and a rounding and saturation stage that doubles as the output register.
// Depends on fpalu_pkg.
module fpalu_back import fpalu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  uop_t        pop_uop,
  fpalu_rsp_if.source rsp
);

  typedef struct packed {
    logic [1:0]        unit;
    logic [DATA_W-1:0] res;
    logic [1:0]        status;
    logic [2:0]        flags;
    logic              neg;
    logic [PROD_W-1:0] prod;
    logic [DATA_W-1:0] dvs;
    logic [DIV_W-1:0]  num;
    logic [DATA_W-1:0] rem;
    logic [DIV_W-1:0]  quo;
  } bst_t;

  bst_t                     st [LAST];
  logic [LAST:0]            vld;
  logic                     adv;
  logic signed [DATA_W-1:0] sa;
  logic signed [DATA_W-1:0] sb;
  logic [DATA_W-1:0]        mag_a;
  logic [DATA_W-1:0]        mag_b;
  logic [PROD_W-1:0]        mag_p;
  logic [PROD_W-1:0]        q_mul;
  logic [PROD_W-1:0]        q_div;
  logic                     round_up;
  sat_t                     sat;
  logic [DATA_W-1:0]        out_res;
  logic [1:0]               out_status;
  logic [2:0]               out_flags;

  assign adv       = !vld[LAST] || rsp.ready;
  assign pop_ready = adv;
  assign sa        = pop_uop.a;
  assign sb        = pop_uop.b;
  assign mag_a     = sa[DATA_W-1] ? DATA_W'(-sa) : pop_uop.a;
  assign mag_b     = sb[DATA_W-1] ? DATA_W'(-sb) : pop_uop.b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].unit   <= pop_uop.unit;
      st[0].res    <= pop_uop.res;
      st[0].status <= pop_uop.status;
      st[0].flags  <= {pop_uop.less, pop_uop.equal, pop_uop.greater};
      st[0].neg    <= sa[DATA_W-1] ^ sb[DATA_W-1];
      st[0].prod   <= PROD_W'(sa * sb);
      st[0].dvs    <= mag_b;
      st[0].num    <= DIV_W'(mag_a) << FRAC_BITS;
      st[0].rem    <= '0;
      st[0].quo    <= '0;
    end
  end

  for (genvar i = 1; i < LAST; i++) begin : g_div
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            ge;
    bst_t            stage_next;

    assign trial = {st[i-1].rem, st[i-1].num[DIV_W-1]};
    assign diff  = trial - {1'b0, st[i-1].dvs};
    assign ge    = trial >= {1'b0, st[i-1].dvs};

    always_comb begin
      stage_next = st[i-1];
      if (st[i-1].unit == UNIT_DIV) begin
        stage_next.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        stage_next.quo = {st[i-1].quo[DIV_W-2:0], ge};
        stage_next.num = st[i-1].num << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[i] <= stage_next;
      end
    end
  end

  always_comb begin
    mag_p    = st[LAST-1].prod[PROD_W-1] ? -st[LAST-1].prod : st[LAST-1].prod;
    q_mul    = (mag_p + MUL_HALF) >> FRAC_BITS;
    round_up = {st[LAST-1].rem, 1'b0} >= {1'b0, st[LAST-1].dvs};
    q_div    = PROD_W'(st[LAST-1].quo) + PROD_W'(round_up);
    case (st[LAST-1].unit)
      UNIT_MUL: sat = sat_mag(q_mul, st[LAST-1].prod[PROD_W-1]);
      UNIT_DIV: sat = sat_mag(q_div, st[LAST-1].neg);
      default: begin
        sat.value  = st[LAST-1].res;
        sat.status = st[LAST-1].status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res    <= sat.value;
      out_status <= sat.status;
      out_flags  <= st[LAST-1].flags;
    end
  end

  assign rsp.valid        = vld[LAST];
  assign rsp.result_value = out_res;
  assign rsp.status_code  = out_status;
  assign rsp.a_less       = out_flags[2];
  assign rsp.a_equal      = out_flags[1];
  assign rsp.a_greater    = out_flags[0];

endmodule

// ===== design/fixed_point_alu_unit.sv =====
// Top level of the fixed-point ALU: front end, request queue and back end.
// Depends on fpalu_pkg, fpalu_if, fpalu_front, fpalu_queue and fpalu_back.
//
//   Channel  Direction  Fields
//   req      in         req_type, operand_a, operand_b
//   rsp      out        result_value, a_less, a_equal, a_greater, status_code
//
// One request is taken every cycle unless a full queue holds the front end;
// every result passes the back end's one-quotient-bit-per-stage divider.
// Every operation passes the same pipeline, so results keep request order.
// Reset clears only valid bits, queue count and pointers. A stalled response
// holds the whole back end; front end and queue accept requests until full.
module fixed_point_alu_unit import fpalu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  fpalu_req_if.sink   req,
  fpalu_rsp_if.source rsp
);

  logic push_valid;
  logic push_ready;
  uop_t push_uop;
  logic pop_valid;
  logic pop_ready;
  uop_t pop_uop;

  fpalu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_uop   (push_uop)
  );

  fpalu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_uop   (push_uop),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_uop    (pop_uop)
  );

  fpalu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_uop   (pop_uop),
    .rsp       (rsp)
  );

endmodule

// ===== design/fpalu_checker.sv =====
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fpalu_pkg and fixed_point_alu_unit.
module fpalu_checker import fpalu_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [DATA_W-1:0] result_value,
  input logic              a_less,
  input logic              a_equal,
  input logic              a_greater,
  input logic [1:0]        status_code
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("Response valid after reset.");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot({a_less, a_equal, a_greater}))
    else $error("Comparison flags not one-hot.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status_code == ST_OK || status_code == ST_DIV_ZERO ||
                   status_code == ST_OVERFLOW))
    else $error("Undefined status code.");

  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status_code == ST_DIV_ZERO |-> result_value == '0)
    else $error("Divide by zero with non-zero result.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value))
    else $error("Stalled response changed.");

endmodule

bind fixed_point_alu_unit fpalu_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .result_value (rsp.result_value),
  .a_less       (rsp.a_less),
  .a_equal      (rsp.a_equal),
  .a_greater    (rsp.a_greater),
  .status_code  (rsp.status_code)
);
